>>> rtl/position_energy_histogram_macros.svh
// Assertion macros shared by the position-energy histogram RTL.
// Stands alone; included by the modules that carry assertions.
`ifndef POSITION_ENERGY_HISTOGRAM_MACROS_SVH
`define POSITION_ENERGY_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PEH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PEH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/peh_pkg.sv
// Shared constants, types and register codes for the position-energy histogram.
// No dependencies; imported by every module of the block.
package peh_pkg;

  localparam int MAX_POSITION_BINS = 64;
  localparam int MAX_ENERGY_BINS   = 64;
  localparam int COUNT_WIDTH       = 32;

  localparam int DATA_W      = 32;
  localparam int USED_W      = 7;
  localparam int INDEX_W     = 3;
  localparam int POS_BIN_W   = $clog2(MAX_POSITION_BINS);
  localparam int ENG_BIN_W   = $clog2(MAX_ENERGY_BINS);
  localparam int STORE_DEPTH = MAX_POSITION_BINS * MAX_ENERGY_BINS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int FRONT_STAGES  = 3;
  localparam int INFLIGHT_W    = $clog2(FRONT_STAGES + 1);

  // 0.511 MeV as unsigned Q0.32, and 1.0 as Q16.16.
  localparam logic [DATA_W-1:0] REST_MASS_Q032 = 32'd2194719883;
  localparam logic [DATA_W:0]   ONE_Q16        = 33'd65536;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_MIN_POSITION       = 3'd0;
  localparam logic [INDEX_W-1:0] REG_BINS_PER_UNIT      = 3'd1;
  localparam logic [INDEX_W-1:0] REG_MIN_ENERGY_MEV     = 3'd2;
  localparam logic [INDEX_W-1:0] REG_POSITION_BINS_USED = 3'd3;
  localparam logic [INDEX_W-1:0] REG_ENERGY_BINS_USED   = 3'd4;

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_READ       = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] min_position;
    logic [DATA_W-1:0] bins_per_unit;
    logic [DATA_W-1:0] min_energy_mev;
    logic [USED_W-1:0] position_bins_used;
    logic [USED_W-1:0] energy_bins_used;
  } cfg_t;

  // One classified operation handed from the front to the back.
  typedef struct packed {
    logic                 is_acc;
    logic                 ok;
    logic [POS_BIN_W-1:0] pb;
    logic [ENG_BIN_W-1:0] eb;
  } op_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

>>> rtl/peh_front.sv
// Front end: three-stage binning pipeline that classifies each transfer.
// Depends on peh_pkg; feeds peh_queue.
module peh_front import peh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  accept,
  input  logic                  command,
  input  logic [DATA_W-1:0]     position,
  input  logic [DATA_W-1:0]     lorentz_factor,
  input  logic [POS_BIN_W-1:0]  read_position_bin,
  input  logic [ENG_BIN_W-1:0]  read_energy_bin,
  output logic                  push,
  output op_t                   push_op,
  output logic [INFLIGHT_W-1:0] inflight
);

  // Stage 1: offsets and magnitudes.
  logic                 v1, cmd1, dneg1, gneg1;
  logic [DATA_W-1:0]    dmag1, gmag1;
  logic [POS_BIN_W-1:0] rpb1, rpb2, rpb3;
  logic [ENG_BIN_W-1:0] reb1, reb2, reb3;
  // Stage 2: products.
  logic                 v2, cmd2, dneg2, gneg2;
  logic [2*DATA_W-1:0]  pprod2, eprod2;
  // Stage 3: position decided, energy offset formed.
  logic                 v3, cmd3, pos_ok3, rd_ok3, qneg3;
  logic [POS_BIN_W-1:0] pb3;
  logic [48:0]          qmag3;

  logic [DATA_W:0]      d, g, dabs, gabs;
  logic [USED_W-1:0]    plim, elim;
  logic                 pneg;
  logic [DATA_W-1:0]    pip;
  logic [47:0]          emag;
  logic [49:0]          e_s, mine_sh, q, qabs;
  logic [16:0]          qip;
  logic                 e_ok, ok;

  assign plim = (cfg.position_bins_used > USED_W'(MAX_POSITION_BINS)) ?
                USED_W'(MAX_POSITION_BINS) : cfg.position_bins_used;
  assign elim = (cfg.energy_bins_used > USED_W'(MAX_ENERGY_BINS)) ?
                USED_W'(MAX_ENERGY_BINS) : cfg.energy_bins_used;

  always_comb begin
    d    = {position[DATA_W-1], position} -
           {cfg.min_position[DATA_W-1], cfg.min_position};
    dabs = d[DATA_W] ? (~d + 1'b1) : d;
    g    = {1'b0, lorentz_factor} - ONE_Q16;
    gabs = g[DATA_W] ? (~g + 1'b1) : g;
  end

  always_comb begin
    pneg    = dneg2 && (pprod2 != '0);
    pip     = pprod2[2*DATA_W-1:DATA_W];
    emag    = eprod2[63:16];
    e_s     = gneg2 ? (50'd0 - {2'b00, emag}) : {2'b00, emag};
    mine_sh = {{2{cfg.min_energy_mev[DATA_W-1]}}, cfg.min_energy_mev, 16'd0};
    q       = e_s - mine_sh;
    qabs    = q[49] ? (50'd0 - q) : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
    cmd1  <= command;
    dneg1 <= d[DATA_W];
    gneg1 <= g[DATA_W];
    dmag1 <= dabs[DATA_W-1:0];
    gmag1 <= gabs[DATA_W-1:0];
    rpb1  <= read_position_bin;
    reb1  <= read_energy_bin;

    cmd2   <= cmd1;
    dneg2  <= dneg1;
    gneg2  <= gneg1;
    pprod2 <= dmag1 * cfg.bins_per_unit;
    eprod2 <= gmag1 * REST_MASS_Q032;
    rpb2   <= rpb1;
    reb2   <= reb1;

    cmd3    <= cmd2;
    pos_ok3 <= !(pneg && (pip != '0)) && (pip < DATA_W'(plim));
    pb3     <= pip[POS_BIN_W-1:0];
    rd_ok3  <= (USED_W'(rpb2) < plim) && (USED_W'(reb2) < elim);
    qneg3   <= q[49];
    qmag3   <= qabs[48:0];
    rpb3    <= rpb2;
    reb3    <= reb2;
  end

  always_comb begin
    qip  = qmag3[48:32];
    e_ok = !(qneg3 && (qip != '0)) && (qip < 17'(elim));
    ok   = (cmd3 == CMD_READ) ? rd_ok3 : (pos_ok3 && e_ok);
    push_op.is_acc = (cmd3 == CMD_ACCUMULATE);
    push_op.ok     = ok;
    if (cmd3 == CMD_READ) begin
      push_op.pb = rpb3;
      push_op.eb = reb3;
    end else begin
      push_op.pb = pb3;
      push_op.eb = qip[ENG_BIN_W-1:0];
    end
  end

  assign push     = v3;
  assign inflight = INFLIGHT_W'(v1) + INFLIGHT_W'(v2) + INFLIGHT_W'(v3);

endmodule

>>> rtl/peh_queue.sv
// Short operation queue between the binning front and the counter back.
// Depends on peh_pkg and the assertion macro header.
`include "position_energy_histogram_macros.svh"

module peh_queue import peh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  op_t       push_op,
  input  logic      pop,
  output op_t       head,
  output q_status_t status
);

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));

  `PEH_ASSERT_NOW(a_no_push_when_full, clk, rst, push, !status.full, "push into full queue")
  `PEH_ASSERT_NOW(a_no_pop_when_empty, clk, rst, pop, !status.empty, "pop from empty queue")

endmodule

>>> rtl/peh_back.sv
// Back end: count store with clearing sweep, read-modify-write sequencer and
// output register. Depends on peh_pkg and the assertion macro header.
`include "position_energy_histogram_macros.svh"

module peh_back import peh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  op_t                    head,
  input  q_status_t              q_status,
  output logic                   pop,
  output logic                   clearing,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [POS_BIN_W-1:0]   position_bin,
  output logic [ENG_BIN_W-1:0]   energy_bin,
  output logic                   in_range,
  output logic [COUNT_WIDTH-1:0] bin_count
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]             state, state_next;
  logic [ADDR_W-1:0]      clear_addr;
  op_t                    hold;
  logic [COUNT_WIDTH-1:0] store [STORE_DEPTH];
  logic [COUNT_WIDTH-1:0] rdata, incr;
  logic [ADDR_W-1:0]      head_addr, hold_addr, waddr;
  logic                   out_free, mem_re, mem_we, finish;
  logic [COUNT_WIDTH-1:0] wdata;

  assign out_free  = !out_valid || !out_stall;
  assign head_addr = ADDR_W'(head.pb) * ADDR_W'(MAX_ENERGY_BINS) + ADDR_W'(head.eb);
  assign hold_addr = ADDR_W'(hold.pb) * ADDR_W'(MAX_ENERGY_BINS) + ADDR_W'(hold.eb);
  assign incr      = (rdata == COUNT_MAX) ? rdata : rdata + 1'b1;
  assign clearing  = (state == ST_CLEAR);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clear_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_status.empty && out_free) begin
          pop = 1'b1;
          if (head.ok) begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign mem_re = pop && head.ok;
  assign mem_we = clearing || (finish && hold.is_acc);
  assign waddr  = clearing ? clear_addr : hold_addr;
  assign wdata  = clearing ? '0 : incr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= store[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if ((pop && !head.ok) || finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      hold <= head;
    end
    if (pop && !head.ok) begin
      position_bin <= '0;
      energy_bin   <= '0;
      in_range     <= 1'b0;
      bin_count    <= '0;
    end else if (finish) begin
      position_bin <= hold.pb;
      energy_bin   <= hold.eb;
      in_range     <= 1'b1;
      bin_count    <= hold.is_acc ? incr : rdata;
    end
  end

  `PEH_ASSERT_NOW(a_no_pop_while_clearing, clk, rst, clearing, !pop, "queue popped during clear")
  `PEH_ASSERT_NEXT(a_count_increments, clk, rst, finish && hold.is_acc && (rdata != COUNT_MAX), bin_count == COUNT_WIDTH'($past(rdata) + 1'b1), "count not incremented")
  `PEH_ASSERT_NOW(a_out_of_range_zero, clk, rst, out_valid && !in_range, (bin_count == '0) && (position_bin == '0) && (energy_bin == '0), "out-of-range result not zeroed")

endmodule

>>> rtl/position_energy_histogram.sv
// Position-by-energy histogram: items pass the three front stages and the queue; the back
// registers an out-of-range result on the pop, and for an in-range item reads the count on
// the pop and registers the result in its update state. The front takes new transfers while
// earlier ones are in flight; the back ends each read-modify-write before its next pop, and
// in_stall counts a queue entry popped that cycle as taken. Reset (synchronous, active high)
// loads the register defaults, then a sweep zeroes all 4096 counts while in_stall stays high.
module position_energy_histogram import peh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   config_write,
  input  logic [INDEX_W-1:0]     config_index,
  input  logic [DATA_W-1:0]      config_data,
  // Input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   command,
  input  logic [DATA_W-1:0]      position,
  input  logic [DATA_W-1:0]      lorentz_factor,
  input  logic [POS_BIN_W-1:0]   read_position_bin,
  input  logic [ENG_BIN_W-1:0]   read_energy_bin,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [POS_BIN_W-1:0]   position_bin,
  output logic [ENG_BIN_W-1:0]   energy_bin,
  output logic                   in_range,
  output logic [COUNT_WIDTH-1:0] bin_count
);

  cfg_t                  cfg;
  logic                  accept;
  logic                  push, pop, clearing;
  op_t                   push_op, head;
  q_status_t             q_status;
  logic [INFLIGHT_W-1:0] inflight;
  logic [QCNT_W:0]       slots_used;

  // Configuration registers. The user must make writes only while the block is idle; the
  // block does not enforce this, and the front pipeline reads them directly without shadowing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_position       <= '0;
      cfg.bins_per_unit      <= DATA_W'(32'h0001_0000);
      cfg.min_energy_mev     <= '0;
      cfg.position_bins_used <= USED_W'(MAX_POSITION_BINS);
      cfg.energy_bins_used   <= USED_W'(MAX_ENERGY_BINS);
    end else if (config_write) begin
      unique case (config_index)
        REG_MIN_POSITION:       cfg.min_position       <= config_data;
        REG_BINS_PER_UNIT:      cfg.bins_per_unit      <= config_data;
        REG_MIN_ENERGY_MEV:     cfg.min_energy_mev     <= config_data;
        REG_POSITION_BINS_USED: cfg.position_bins_used <= config_data[USED_W-1:0];
        REG_ENERGY_BINS_USED:   cfg.energy_bins_used   <= config_data[USED_W-1:0];
        default: ;
      endcase
    end
  end

  // The front pipeline never stalls once an item is in it, so the input takes a
  // transfer only while the queue has a free slot for every item in flight and for the new one.
  // Both terms come from registers, so in_stall never looks at in_valid.
  assign slots_used = (QCNT_W + 1)'(q_status.count) + (QCNT_W + 1)'(inflight);
  assign in_stall   = clearing || (slots_used >= (QCNT_W + 1)'(QUEUE_DEPTH));
  assign accept     = in_valid && !in_stall;

  peh_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .accept            (accept),
    .command           (command),
    .position          (position),
    .lorentz_factor    (lorentz_factor),
    .read_position_bin (read_position_bin),
    .read_energy_bin   (read_energy_bin),
    .push              (push),
    .push_op           (push_op),
    .inflight          (inflight)
  );

  // The queue decouples the fixed-latency front from the back, whose pace is
  // set by the store's read-modify-write and by stalls on the result side.
  peh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  // The back reads a count when it pops an in-range item and, for accumulates,
  // writes the incremented value in its update state when out_free holds; the
  // next pop follows that write, so back-to-back hits on one bin see it updated.
  peh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .position_bin (position_bin),
    .energy_bin   (energy_bin),
    .in_range     (in_range),
    .bin_count    (bin_count)
  );

endmodule
